// ===== src/console_line_editor_defines.svh =====
// Assertion macros for the console line editor.
// Included by the top level; expects clk and rst_n in scope.
`ifndef CONSOLE_LINE_EDITOR_DEFINES_SVH
`define CONSOLE_LINE_EDITOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define CLE_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define CLE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/cle_pkg.sv =====
// Shared types, character codes and sizes for the console line editor.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package cle_pkg;

  localparam int LINE_CAPACITY_DEF = 16;
  localparam int CMDQ_DEPTH        = 4;
  localparam int CMDQ_PTR_W        = 2;
  localparam int ADDR_W            = 5;
  localparam int CNT_W             = 6;
  localparam int INTR_TEXT_LEN     = 10;

  localparam logic [7:0] CH_ETX = 8'h03;
  localparam logic [7:0] CH_BS  = 8'h08;
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_NAK = 8'h15;
  localparam logic [7:0] CH_ESC = 8'h1B;
  localparam logic [7:0] CH_SP  = 8'h20;

  typedef enum logic [1:0] {
    KIND_ECHO = 2'd0,
    KIND_LINE = 2'd1,
    KIND_END  = 2'd2,
    KIND_INTR = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    OP_ECHO  = 2'd0,
    OP_ERASE = 2'd1,
    OP_LINE  = 2'd2,
    OP_INTR  = 2'd3
  } op_t;

  typedef struct packed {
    op_t              op;
    logic [7:0]       chr;
    logic [CNT_W-1:0] count;
  } cmd_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        data;
  } store_wr_t;

  // Text echoed for an interrupt, CR and LF included.
  function automatic logic [7:0] intr_char(input logic [3:0] idx);
    logic [7:0] c;
    case (idx)
      4'd0:    c = 8'h3C;
      4'd1:    c = 8'h63;
      4'd2:    c = 8'h74;
      4'd3:    c = 8'h72;
      4'd4:    c = 8'h6C;
      4'd5:    c = 8'h2D;
      4'd6:    c = 8'h63;
      4'd7:    c = 8'h3E;
      4'd8:    c = CH_CR;
      4'd9:    c = CH_LF;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

// ===== src/cle_front.sv =====
// Front end: accepts console bytes, tracks the fill count and issues commands.
// Depends on cle_pkg.
`timescale 1ns / 1ps

module cle_front #(
  parameter int LINE_CAPACITY = cle_pkg::LINE_CAPACITY_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  output logic               in_full,
  input  logic [7:0]         in_rx_byte,
  input  logic               q_full,
  output logic               q_push,
  output cle_pkg::cmd_t      q_cmd,
  output cle_pkg::store_wr_t st_wr,
  input  logic               line_done,
  output logic               lock
);

  localparam int DEPTH  = LINE_CAPACITY - 1;
  localparam int FILL_W = $clog2(LINE_CAPACITY);

  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic              lock_r, lock_nxt;
  logic              accept;
  logic              has_cmd;

  assign in_full = q_full || lock_r;
  assign accept  = in_push && !in_full;
  assign q_push  = accept && has_cmd;
  assign lock    = lock_r;

  always_comb begin
    has_cmd       = 1'b0;
    q_cmd.op      = cle_pkg::OP_ECHO;
    q_cmd.chr     = in_rx_byte;
    q_cmd.count   = '0;
    fill_nxt      = fill_r;
    st_wr.en      = 1'b0;
    st_wr.addr    = cle_pkg::ADDR_W'(fill_r);
    st_wr.data    = in_rx_byte;
    case (in_rx_byte)
      cle_pkg::CH_CR, cle_pkg::CH_LF: begin
        has_cmd     = 1'b1;
        q_cmd.op    = cle_pkg::OP_LINE;
        q_cmd.count = cle_pkg::CNT_W'(fill_r);
        fill_nxt    = '0;
      end
      cle_pkg::CH_ESC: begin
        // The line is dropped before delivery, so the line end is empty.
        has_cmd  = 1'b1;
        q_cmd.op = cle_pkg::OP_LINE;
        fill_nxt = '0;
      end
      cle_pkg::CH_NAK: begin
        has_cmd     = (fill_r != '0);
        q_cmd.op    = cle_pkg::OP_ERASE;
        q_cmd.count = cle_pkg::CNT_W'(fill_r);
        fill_nxt    = '0;
      end
      cle_pkg::CH_BS: begin
        has_cmd     = (fill_r != '0);
        q_cmd.op    = cle_pkg::OP_ERASE;
        q_cmd.count = cle_pkg::CNT_W'(1);
        if (fill_r != '0) begin
          fill_nxt = fill_r - FILL_W'(1);
        end
      end
      cle_pkg::CH_ETX: begin
        has_cmd  = 1'b1;
        q_cmd.op = cle_pkg::OP_INTR;
        fill_nxt = '0;
      end
      default: begin
        if (fill_r < FILL_W'(DEPTH)) begin
          has_cmd  = 1'b1;
          st_wr.en = accept;
          fill_nxt = fill_r + FILL_W'(1);
        end
      end
    endcase
  end

  // The store stays frozen from the issue of a non-empty line until its end.
  always_comb begin
    lock_nxt = lock_r;
    if (line_done) begin
      lock_nxt = 1'b0;
    end
    if (q_push && q_cmd.op == cle_pkg::OP_LINE && q_cmd.count != '0) begin
      lock_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
      lock_r <= 1'b0;
    end else begin
      lock_r <= lock_nxt;
      if (accept) begin
        fill_r <= fill_nxt;
      end
    end
  end

endmodule

// ===== src/cle_cmd_fifo.sv =====
// Short command queue between the front and back ends.
// Depends on cle_pkg.
`timescale 1ns / 1ps

module cle_cmd_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  cle_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output logic          empty,
  output cle_pkg::cmd_t head
);

  localparam int CNT_W = cle_pkg::CMDQ_PTR_W + 1;

  cle_pkg::cmd_t                 mem_r [cle_pkg::CMDQ_DEPTH];
  logic [cle_pkg::CMDQ_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]               cnt_r, cnt_nxt;
  logic                           do_push, do_pop;

  assign full    = (cnt_r == CNT_W'(cle_pkg::CMDQ_DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = mem_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + cle_pkg::CMDQ_PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + cle_pkg::CMDQ_PTR_W'(1);
      end
    end
  end

endmodule

// ===== src/cle_back.sv =====
// Back end: holds the line store and expands each command into result items.
// Depends on cle_pkg.
`timescale 1ns / 1ps

module cle_back #(
  parameter int LINE_CAPACITY = cle_pkg::LINE_CAPACITY_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  cle_pkg::store_wr_t st_wr,
  input  logic               q_empty,
  input  cle_pkg::cmd_t      q_head,
  output logic               q_pop,
  output logic               line_done,
  output logic               out_empty,
  input  logic               out_pop,
  output logic [1:0]         out_item_kind,
  output logic [7:0]         out_byte,
  output logic [5:0]         out_line_length,
  output logic               out_last_item
);

  localparam int DEPTH = LINE_CAPACITY - 1;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = cle_pkg::CNT_W;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } state_t;

  state_t            state_r, state_nxt;
  cle_pkg::cmd_t     cmd_r;
  logic [CW-1:0]     idx_r;
  logic [CW-1:0]     rep_r;
  logic [1:0]        ph_r;
  logic [7:0]        store_r [DEPTH];
  logic              ov_r;
  logic [1:0]        kind_r;
  logic [7:0]        byte_r;
  logic [5:0]        len_r;
  logic              last_r;

  logic              load;
  cle_pkg::kind_t    g_kind;
  logic [7:0]        g_byte;
  logic [5:0]        g_len;
  logic              g_last;
  logic [CW-1:0]     idx_off;
  logic [CW-1:0]     end_idx;

  assign out_empty       = !ov_r;
  assign out_item_kind   = kind_r;
  assign out_byte        = byte_r;
  assign out_line_length = len_r;
  assign out_last_item   = last_r;

  assign q_pop     = (state_r == ST_IDLE) && !q_empty;
  assign load      = (state_r == ST_RUN) && (!ov_r || out_pop);
  assign line_done = load && g_last && cmd_r.op == cle_pkg::OP_LINE && cmd_r.count != '0;

  assign idx_off = idx_r - CW'(2);
  assign end_idx = cmd_r.count + CW'(2);

  always_comb begin
    g_kind = cle_pkg::KIND_ECHO;
    g_byte = cmd_r.chr;
    g_len  = '0;
    g_last = 1'b0;
    case (cmd_r.op)
      cle_pkg::OP_ECHO: begin
        g_last = 1'b1;
      end
      cle_pkg::OP_ERASE: begin
        g_byte = (ph_r == 2'd1) ? cle_pkg::CH_SP : cle_pkg::CH_BS;
        g_last = (ph_r == 2'd2) && (rep_r == CW'(1));
      end
      cle_pkg::OP_LINE: begin
        if (idx_r == CW'(0)) begin
          g_byte = cle_pkg::CH_CR;
        end else if (idx_r == CW'(1)) begin
          g_byte = cle_pkg::CH_LF;
        end else if (idx_r != end_idx) begin
          g_kind = cle_pkg::KIND_LINE;
          g_byte = store_r[idx_off[AW-1:0]];
        end else begin
          g_kind = cle_pkg::KIND_END;
          g_len  = 6'(cmd_r.count);
          g_last = 1'b1;
        end
      end
      cle_pkg::OP_INTR: begin
        if (idx_r < CW'(cle_pkg::INTR_TEXT_LEN)) begin
          g_byte = cle_pkg::intr_char(idx_r[3:0]);
        end else begin
          g_kind = cle_pkg::KIND_INTR;
          g_last = 1'b1;
        end
      end
      default: begin
        g_last = 1'b1;
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (!q_empty) begin
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        if (load && g_last) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (st_wr.en) begin
      store_r[st_wr.addr[AW-1:0]] <= st_wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cmd_r <= q_head;
      idx_r <= '0;
      rep_r <= q_head.count;
      ph_r  <= 2'd0;
    end else if (load) begin
      idx_r <= idx_r + CW'(1);
      if (ph_r == 2'd2) begin
        ph_r  <= 2'd0;
        rep_r <= rep_r - CW'(1);
      end else begin
        ph_r <= ph_r + 2'd1;
      end
    end
    if (load) begin
      kind_r <= g_kind;
      byte_r <= g_byte;
      len_r  <= g_len;
      last_r <= g_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (load) begin
        ov_r <= 1'b1;
      end else if (out_pop) begin
        ov_r <= 1'b0;
      end
    end
  end

endmodule

// ===== src/console_line_editor.sv =====
// Top level of the console line editor: front end, command queue, back end.
// Depends on cle_pkg, cle_front, cle_cmd_fifo, cle_back and the defines header.
`timescale 1ns / 1ps
`include "console_line_editor_defines.svh"

//  channel   ports                                   request moves when
//  -------   -------------------------------------   -----------------------
//  input     in_push, in_full, in_rx_byte            in_push && !in_full
//  result    out_pop, out_empty, out_item_kind,      out_pop && !out_empty
//            out_byte, out_line_length, out_last_item
//
// The front end takes one byte a cycle while the command queue has room. It is
// held off from the issue of a non-empty line until that line's end item is
// formed, because the back end reads the line store while delivering it.
// The back end takes a command and then forms one result per cycle while
// the result register is free or popped, so a byte yields from no result
// (dropped) up to 45 results at the default capacity (Ctrl-U on a full line
// of 15 bytes: three echoes per stored byte); a stalled result register holds
// the back end and, once the queue fills, the front end. Reset is synchronous
// and active low; it empties the line, the queue and the result register.

module console_line_editor #(
  parameter int LINE_CAPACITY = cle_pkg::LINE_CAPACITY_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_push,
  output logic       in_full,
  input  logic [7:0] in_rx_byte,
  output logic       out_empty,
  input  logic       out_pop,
  output logic [1:0] out_item_kind,
  output logic [7:0] out_byte,
  output logic [5:0] out_line_length,
  output logic       out_last_item
);

  localparam int DEPTH = LINE_CAPACITY - 1;

  cle_pkg::cmd_t      push_cmd;
  cle_pkg::cmd_t      head_cmd;
  cle_pkg::store_wr_t st_wr;
  logic               q_push, q_full, q_pop, q_empty;
  logic               line_done;
  logic               front_lock;

  // Classifies each byte, keeps the fill count and writes plain bytes.
  cle_front #(
    .LINE_CAPACITY(LINE_CAPACITY)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_rx_byte(in_rx_byte),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_cmd     (push_cmd),
    .st_wr     (st_wr),
    .line_done (line_done),
    .lock      (front_lock)
  );

  // Decouples classification from result generation.
  cle_cmd_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .push_cmd(push_cmd),
    .full    (q_full),
    .pop     (q_pop),
    .empty   (q_empty),
    .head    (head_cmd)
  );

  // Expands commands into echo, line, line-end and interrupt results.
  cle_back #(
    .LINE_CAPACITY(LINE_CAPACITY)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .st_wr          (st_wr),
    .q_empty        (q_empty),
    .q_head         (head_cmd),
    .q_pop          (q_pop),
    .line_done      (line_done),
    .out_empty      (out_empty),
    .out_pop        (out_pop),
    .out_item_kind  (out_item_kind),
    .out_byte       (out_byte),
    .out_line_length(out_line_length),
    .out_last_item  (out_last_item)
  );

  // The store must not change while a line is waiting or being delivered.
  `CLE_ASSERT_IMPL(a_no_write_when_locked, front_lock, !st_wr.en,
                   "store written during line delivery")
  // The front end never pushes into a full queue.
  `CLE_ASSERT_IMPL(a_no_push_when_full, q_push, !q_full,
                   "command pushed into full queue")
  // Only a line end carries a length, and it never exceeds the store depth.
  `CLE_ASSERT_IMPL(a_len_only_on_end,
                   !out_empty && out_item_kind != cle_pkg::KIND_END,
                   out_line_length == 6'd0, "length on non line-end result")
  `CLE_ASSERT_IMPL(a_len_in_range, !out_empty, out_line_length <= 6'(DEPTH),
                   "line length beyond store depth")

endmodule
